@@ rtl/protocol_port_class_table_defines.svh @@
// ---------------------------------------------------------------------------
// Protocol/port classification table: assertion macros
// Shared property shapes for the checks in the table logic.
// ---------------------------------------------------------------------------
`ifndef PROTOCOL_PORT_CLASS_TABLE_DEFINES_SVH
`define PROTOCOL_PORT_CLASS_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPCT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PPCT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ppct_pkg.sv @@
// ---------------------------------------------------------------------------
// ppct_pkg
// Types and constants of the protocol/port classification table.
// ---------------------------------------------------------------------------
package ppct_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  // Insert status codes
  localparam logic [1:0] ST_NEW       = 2'd0;
  localparam logic [1:0] ST_OVERWRITE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] protocol;
    logic        port_any;
    logic [15:0] port;
    logic        new_valid;
    logic        new_dup_ip;
    logic        new_dup_mac;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic       via_wildcard;
    logic       type_valid;
    logic       dup_ip;
    logic       dup_mac;
    logic [1:0] insert_status;
  } rsp_t;

  typedef struct packed {
    logic type_valid;
    logic dup_ip;
    logic dup_mac;
  } flags_t;

  typedef struct packed {
    logic [15:0] protocol;
    logic        port_any;
    logic [15:0] port;
    flags_t      flags;
  } entry_t;

endpackage

@@ rtl/protocol_port_class_table.sv @@
// ---------------------------------------------------------------------------
// protocol_port_class_table
// Classification table keyed by protocol and port, with any-port fallback.
// ---------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and its result appears on result with done high for one cycle, with
// no way to hold it off. The table sits in a synchronous RAM with one write
// port and one read port that is scanned one entry per cycle over the entries
// in use; busy drops in the cycle done is shown, so the next request can be
// taken right then. One scan serves both the exact key and the any-port key
// of the same protocol. Reset empties the table at once through the fill
// count; no clearing pass is run.
// ---------------------------------------------------------------------------
`include "protocol_port_class_table_defines.svh"

module protocol_port_class_table
  import ppct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  state_t state, state_next;

  entry_t mem [ENTRIES];
  entry_t rd_data;
  logic   mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t mem_wd;

  req_t             req;
  req_t             req_in;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] issue_cnt;
  logic             pend;
  logic [IDX_W-1:0] rd_idx;
  logic             ex_hit;
  logic [IDX_W-1:0] ex_idx;
  flags_t           ex_flags;
  logic             wc_hit;
  flags_t           wc_flags;

  logic   issue;
  logic   ex_match;
  logic   wc_match;
  logic   table_full;
  logic   use_wc;
  logic   is_find;
  rsp_t   rsp_fin;

  assign issue      = (state == S_SCAN) && (issue_cnt < fill_count);
  assign table_full = (fill_count == CNT_W'(ENTRIES));
  assign ex_match   = pend && (rd_data.protocol == req.protocol) &&
                      (rd_data.port_any == req.port_any) && (rd_data.port == req.port);
  assign wc_match   = pend && (rd_data.protocol == req.protocol) && rd_data.port_any;

  // Drop the port of a wildcard key
  always_comb begin
    req_in = request;
    if (request.port_any) begin
      req_in.port = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN:   if (!issue && !pend) state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs and finish-time decisions
  always_comb begin
    busy    = (state != S_IDLE);
    is_find = (req.operation == OP_LOOKUP) || (req.operation == OP_QUERY);
    use_wc  = (req.operation == OP_LOOKUP) && !ex_hit && !req.port_any && wc_hit;
    mem_we  = 1'b0;
    mem_wa  = ex_hit ? ex_idx : fill_count[IDX_W-1:0];
    mem_wd.protocol = req.protocol;
    mem_wd.port_any = req.port_any;
    mem_wd.port     = req.port;
    mem_wd.flags    = '{type_valid: req.new_valid, dup_ip: req.new_dup_ip,
                        dup_mac: req.new_dup_mac};
    rsp_fin = '0;
    case (state)
      S_FINISH: begin
        if (is_find && (ex_hit || use_wc)) begin
          rsp_fin.hit          = 1'b1;
          rsp_fin.via_wildcard = use_wc;
          rsp_fin.type_valid   = ex_hit ? ex_flags.type_valid : wc_flags.type_valid;
          rsp_fin.dup_ip       = ex_hit ? ex_flags.dup_ip : wc_flags.dup_ip;
          rsp_fin.dup_mac      = ex_hit ? ex_flags.dup_mac : wc_flags.dup_mac;
        end
        if (req.operation == OP_INSERT) begin
          if (ex_hit) begin
            mem_we                = 1'b1;
            rsp_fin.insert_status = ST_OVERWRITE;
          end else if (!table_full) begin
            mem_we                = 1'b1;
            rsp_fin.insert_status = ST_NEW;
          end else begin
            rsp_fin.insert_status = ST_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  // Table RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[issue_cnt[IDX_W-1:0]];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      issue_cnt  <= '0;
      pend       <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      pend  <= issue;
      if (state == S_IDLE) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (mem_we && !ex_hit) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Request capture, scan results and result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req    <= req_in;
      ex_hit <= 1'b0;
      wc_hit <= 1'b0;
    end else begin
      if (ex_match) begin
        ex_hit   <= 1'b1;
        ex_idx   <= rd_idx;
        ex_flags <= rd_data.flags;
      end
      if (wc_match) begin
        wc_hit   <= 1'b1;
        wc_flags <= rd_data.flags;
      end
    end
    rd_idx <= issue_cnt[IDX_W-1:0];
    if (state == S_FINISH) begin
      result <= rsp_fin;
    end
  end

  `PPCT_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CNT_W'(ENTRIES), "fill count over capacity")
  `PPCT_ASSERT_NOW(a_full_status, done && (result.insert_status == ST_FULL), table_full, "full status on a table with room")
  `PPCT_ASSERT_NOW(a_wild_hit, done && result.via_wildcard, result.hit, "wildcard match without hit")
  `PPCT_ASSERT_NEXT(a_take_busy, start && !busy, busy && !done, "accepted request not in progress")

endmodule
